/* src/tspsi_pkg.sv */
package tspsi_pkg;

  // Section length and offset width (length is masked to 10 bits)
  localparam int unsigned LEN_W = 10;

  // Result queue geometry; one header completion pushes up to three results
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;
  localparam int unsigned BURST_MAX = 3;

  // Header parser phase
  typedef enum logic [2:0] {
    PH_IGNORE,
    PH_TABLE_ID,
    PH_LEN_HIGH,
    PH_LEN_LOW,
    PH_BODY
  } phase_t;

  // One result item
  typedef struct packed {
    logic [7:0]       section_byte;
    logic [LEN_W-1:0] byte_offset;
    logic             section_end;
    logic             empty_section;
    logic             last;
  } result_t;

  // Results produced by one input byte
  typedef struct packed {
    logic [1:0]              cnt;
    result_t [BURST_MAX-1:0] res;
  } burst_t;

endpackage

/* src/tspsi_core.sv */
module tspsi_core
  import tspsi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] byte_in,
  input  logic       first_in,
  input  logic       start_in,
  input  logic [7:0] tid_match,
  output burst_t     burst
);

  phase_t           phase_r, phase_nxt;
  logic             open_r, open_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic [LEN_W-1:0] stored_r, stored_nxt;
  logic [7:0]       held_tid_r, held_tid_nxt;
  logic [7:0]       held_hi_r, held_hi_nxt;

  phase_t           phase_eff;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] stored_inc;
  logic [1:0]       hdr_cnt;
  logic [7:0]       hdr_byte [BURST_MAX];

  // Section length: 3 + 16-bit length field, kept to 10 bits
  assign len        = {held_hi_r[1:0], byte_in} + LEN_W'(3);
  assign stored_inc = stored_r + LEN_W'(1);
  assign hdr_cnt    = (len < LEN_W'(3)) ? len[1:0] : 2'd3;

  assign hdr_byte[0] = held_tid_r;
  assign hdr_byte[1] = held_hi_r;
  assign hdr_byte[2] = byte_in;

  // Parse one payload byte and build its results
  always_comb begin
    phase_nxt    = phase_r;
    open_nxt     = open_r;
    total_nxt    = total_r;
    stored_nxt   = stored_r;
    held_tid_nxt = held_tid_r;
    held_hi_nxt  = held_hi_r;
    burst        = '0;

    // First byte of a packet: pointer byte on unit start, else body
    if (first_in) begin
      phase_eff = start_in ? PH_IGNORE : PH_BODY;
    end else begin
      phase_eff = phase_r;
    end

    if (first_in && start_in) begin
      phase_nxt = PH_TABLE_ID;
    end else begin
      phase_nxt = phase_eff;
      unique case (phase_eff)
        PH_TABLE_ID: begin
          if (byte_in == tid_match) begin
            held_tid_nxt = byte_in;
            open_nxt     = 1'b0;
            stored_nxt   = '0;
            phase_nxt    = PH_LEN_HIGH;
          end else begin
            phase_nxt = PH_IGNORE;
          end
        end
        PH_LEN_HIGH: begin
          held_hi_nxt = byte_in;
          phase_nxt   = PH_LEN_LOW;
        end
        PH_LEN_LOW: begin
          total_nxt = len;
          if (len == '0) begin
            // zero length: a single empty marker result
            burst.cnt                  = 2'd1;
            burst.res[0].section_end   = 1'b1;
            burst.res[0].empty_section = 1'b1;
            burst.res[0].last          = 1'b1;
            stored_nxt                 = '0;
            phase_nxt                  = PH_IGNORE;
          end else begin
            burst.cnt = hdr_cnt;
            for (int i = 0; i < BURST_MAX; i++) begin
              burst.res[i].section_byte = hdr_byte[i];
              burst.res[i].byte_offset  = LEN_W'(i);
              burst.res[i].section_end  = (len == LEN_W'(i + 1));
              burst.res[i].last         = (hdr_cnt == 2'(i + 1));
            end
            stored_nxt = LEN_W'(hdr_cnt);
            if (len > LEN_W'(3)) begin
              open_nxt  = 1'b1;
              phase_nxt = PH_BODY;
            end else begin
              phase_nxt = PH_IGNORE;
            end
          end
        end
        PH_BODY: begin
          if (open_r && (stored_r < total_r)) begin
            burst.cnt                 = 2'd1;
            burst.res[0].section_byte = byte_in;
            burst.res[0].byte_offset  = stored_r;
            burst.res[0].section_end  = (stored_inc == total_r);
            burst.res[0].last         = 1'b1;
            stored_nxt                = stored_inc;
            if (stored_inc == total_r) begin
              open_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // nothing moves unless a byte is processed
    if (!fire) begin
      burst.cnt = 2'd0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IGNORE;
      open_r     <= 1'b0;
      total_r    <= '0;
      stored_r   <= '0;
      held_tid_r <= '0;
      held_hi_r  <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      open_r     <= open_nxt;
      total_r    <= total_nxt;
      stored_r   <= stored_nxt;
      held_tid_r <= held_tid_nxt;
      held_hi_r  <= held_hi_nxt;
    end
  end

endmodule

/* src/tspsi_outq.sv */
module tspsi_outq
  import tspsi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  burst_t  push,
  output logic    room,
  output logic    pop_valid,
  input  logic    pop_stall,
  output result_t pop_data
);

  result_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  // Room for a full burst, judged from registered fill only
  assign room      = (cnt_r <= QCNT_W'(QDEPTH - BURST_MAX));
  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && !pop_stall;
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage, up to three consecutive entries per transfer
  always_ff @(posedge clk) begin
    for (int k = 0; k < BURST_MAX; k++) begin
      if (2'(k) < push.cnt) begin
        mem_r[wr_ptr_r + QPTR_W'(k)] <= push.res[k];
      end
    end
  end

endmodule

/* src/ts_psi_section_reassembler_unit.sv */
// An accepted byte waits in the input register, then its results go to the queue.
// Throughput: 1 payload byte per cycle; a byte that completes a section header
// yields up to 3 results, drained one per cycle while out_stall is low from a
// 4-entry queue, and the input stalls while more than one result is queued.
// Reset: synchronous active-low rst_n clears the parser state, the queue
// and the table id register (to 0); no clearing pass is needed.
module ts_psi_section_reassembler_unit
  import tspsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // payload byte input
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_payload_byte,
  input  logic             in_packet_first,
  input  logic             in_unit_start,
  // section byte output
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_section_byte,
  output logic [LEN_W-1:0] out_byte_offset,
  output logic             out_section_end,
  output logic             out_empty_section,
  output logic             out_last,
  // table id register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_table_id_match
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       first_r;
  logic       start_r;
  logic [7:0] tid_match_r;
  logic       room;
  logic       fire;
  logic       in_xfer;
  burst_t     burst;
  result_t    res;

  // Config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tid_match_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tid_match_r <= cfg_table_id_match;
    end
  end

  // Input register; drains when the queue can take a full burst
  assign fire     = vld_r && room;
  assign in_stall = vld_r && !room;
  assign in_xfer  = in_valid && !in_stall;
  assign vld_nxt  = in_xfer ? 1'b1 : (fire ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r  <= in_payload_byte;
      first_r <= in_packet_first;
      start_r <= in_unit_start;
    end
  end

  tspsi_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .byte_in   (byte_r),
    .first_in  (first_r),
    .start_in  (start_r),
    .tid_match (tid_match_r),
    .burst     (burst)
  );

  tspsi_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (burst),
    .room      (room),
    .pop_valid (out_valid),
    .pop_stall (out_stall),
    .pop_data  (res)
  );

  assign out_section_byte  = res.section_byte;
  assign out_byte_offset   = res.byte_offset;
  assign out_section_end   = res.section_end;
  assign out_empty_section = res.empty_section;
  assign out_last          = res.last;

endmodule

/* tb/tspsi_section_checker.sv */
module tspsi_section_checker
  import tspsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       in_payload_byte,
  input  logic             in_packet_first,
  input  logic             in_unit_start,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [7:0]       out_section_byte,
  input  logic [LEN_W-1:0] out_byte_offset,
  input  logic             out_section_end,
  input  logic             out_empty_section,
  input  logic             out_last,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [7:0]       cfg_table_id_match,
  output int               mismatch_count,
  output int               awaited_count
);

  // Shadow of the reassembly state
  logic [7:0]       tid_reg;
  logic             sec_open;
  logic [LEN_W-1:0] sec_len;
  logic [LEN_W-1:0] sec_stored;
  phase_t           phase;
  logic [7:0]       held_id;
  logic [7:0]       held_len_hi;

  // Section bytes predicted but not yet seen on the output
  result_t expected_section_bytes[$];

  task automatic check_field(input string name, input logic [LEN_W-1:0] want_v,
                             input logic [LEN_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Predict the results of one accepted payload byte
  task automatic reassemble_byte(input logic [7:0] b, input logic first,
                                 input logic start);
    result_t    burst [3];
    logic [7:0] hdr [3];
    logic [15:0] sum;
    logic [LEN_W-1:0] len;
    int n;
    int cnt;
    n = 0;
    if (first && start) begin
      // pointer byte of a unit-start packet
      phase = PH_TABLE_ID;
    end else begin
      if (first) phase = PH_BODY;
      case (phase)
        PH_TABLE_ID: begin
          if (b == tid_reg) begin
            held_id    = b;
            sec_open   = 1'b0;
            sec_stored = '0;
            phase      = PH_LEN_HIGH;
          end else begin
            phase = PH_IGNORE;
          end
        end
        PH_LEN_HIGH: begin
          held_len_hi = b;
          phase       = PH_LEN_LOW;
        end
        PH_LEN_LOW: begin
          sum     = {held_len_hi, b} + 16'd3;
          len     = sum[LEN_W-1:0];
          sec_len = len;
          if (len == 0) begin
            // empty section: a single marker result
            burst[0] = '{section_byte: 8'h00, byte_offset: '0, section_end: 1'b1,
                         empty_section: 1'b1, last: 1'b0};
            n          = 1;
            sec_stored = '0;
            phase      = PH_IGNORE;
          end else begin
            hdr[0] = held_id;
            hdr[1] = held_len_hi;
            hdr[2] = b;
            cnt = (len < 3) ? int'(len) : 3;
            for (int i = 0; i < cnt; i++) begin
              burst[i] = '{section_byte: hdr[i], byte_offset: LEN_W'(i),
                           section_end: (i + 1 == int'(len)), empty_section: 1'b0,
                           last: 1'b0};
            end
            n          = cnt;
            sec_stored = LEN_W'(cnt);
            if (len > 3) begin
              sec_open = 1'b1;
              phase    = PH_BODY;
            end else begin
              phase = PH_IGNORE;
            end
          end
        end
        PH_BODY: begin
          if (sec_open && sec_stored < sec_len) begin
            sec_stored = sec_stored + 1'b1;
            burst[0] = '{section_byte: b, byte_offset: sec_stored - 1'b1,
                         section_end: (sec_stored == sec_len), empty_section: 1'b0,
                         last: 1'b0};
            n = 1;
            if (sec_stored == sec_len) sec_open = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (n > 0) burst[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_section_bytes.push_back(burst[i]);
  endtask

  // Watch all three channels at each rising edge
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      tid_reg        = 8'h00;
      sec_open       = 1'b0;
      sec_len        = '0;
      sec_stored     = '0;
      phase          = PH_IGNORE;
      held_id        = 8'h00;
      held_len_hi    = 8'h00;
      mismatch_count = 0;
      expected_section_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) tid_reg = cfg_table_id_match;
      if (in_valid && !in_stall)
        reassemble_byte(in_payload_byte, in_packet_first, in_unit_start);
      if (out_valid && !out_stall) begin
        if (expected_section_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %0d offset %0d",
                   $time, out_section_byte, out_byte_offset);
          mismatch_count++;
        end else begin
          want = expected_section_bytes.pop_front();
          check_field("section_byte", LEN_W'(want.section_byte),
                      LEN_W'(out_section_byte));
          check_field("byte_offset", want.byte_offset, out_byte_offset);
          check_field("section_end", LEN_W'(want.section_end),
                      LEN_W'(out_section_end));
          check_field("empty_section", LEN_W'(want.empty_section),
                      LEN_W'(out_empty_section));
          check_field("last", LEN_W'(want.last), LEN_W'(out_last));
        end
      end
    end
    awaited_count = expected_section_bytes.size();
  end

endmodule

/* tb/ts_psi_section_reassembler_unit_test.sv */
module ts_psi_section_reassembler_unit_test;
  import tspsi_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       start;
  } ts_byte_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_payload_byte;
  logic             in_packet_first;
  logic             in_unit_start;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_section_byte;
  logic [LEN_W-1:0] out_byte_offset;
  logic             out_section_end;
  logic             out_empty_section;
  logic             out_last;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [7:0]       cfg_table_id_match;

  int mismatch_count;
  int awaited_count;
  int cycle_count = 0;
  int hold_requests = 0;
  ts_byte_t payload_q[$];
  logic [7:0] tid_cur;

  always #5 clk = ~clk;

  ts_psi_section_reassembler_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_payload_byte   (in_payload_byte),
    .in_packet_first   (in_packet_first),
    .in_unit_start     (in_unit_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_section_byte  (out_section_byte),
    .out_byte_offset   (out_byte_offset),
    .out_section_end   (out_section_end),
    .out_empty_section (out_empty_section),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_table_id_match(cfg_table_id_match)
  );

  tspsi_section_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_payload_byte   (in_payload_byte),
    .in_packet_first   (in_packet_first),
    .in_unit_start     (in_unit_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_section_byte  (out_section_byte),
    .out_byte_offset   (out_byte_offset),
    .out_section_end   (out_section_end),
    .out_empty_section (out_empty_section),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_table_id_match(cfg_table_id_match),
    .mismatch_count    (mismatch_count),
    .awaited_count     (awaited_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ts_psi_section_reassembler_unit_test failed");
      $finish;
    end
  end

  // Receiver: stall patterns in stretches, plus an occasional long hold-off
  initial begin : receiver
    int mode;
    int stretch;
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(10, 60);
      repeat (stretch) begin
        @(negedge clk);
        if (hold_requests != hold_seen) begin
          hold_seen = hold_requests;
          hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
          out_stall <= 1'b1;
          hold_left--;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic first, input logic start);
    payload_q.push_back('{data: b, first: first, start: start});
  endtask

  // Random traffic: mostly well-formed sections split over packets, some stray bytes
  task automatic build_section_traffic(input int n_items, input logic [7:0] tid);
    int stop;
    int body_n;
    int pkt_left;
    logic [7:0] id;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [15:0] sum;
    int len;
    stop = payload_q.size() + n_items;
    while (payload_q.size() < stop) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        id  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : tid;
        hi  = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00;
        lo  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30));
        sum = {hi, lo} + 16'd3;
        len = int'(sum[LEN_W-1:0]);
        queue_byte(8'($urandom), 1'b1, 1'b1);
        queue_byte(id, 1'b0, 1'($urandom_range(0, 1)));
        // now and then the header is cut short by the next packet
        if ($urandom_range(0, 9) != 0) begin
          queue_byte(hi, 1'b0, 1'($urandom_range(0, 1)));
          queue_byte(lo, 1'b0, 1'($urandom_range(0, 1)));
          body_n = (len > 3) ? len - 3 : 0;
          if (body_n > 40) body_n = $urandom_range(0, 40);
          body_n += $urandom_range(0, 2);
          pkt_left = $urandom_range(0, 8);
          repeat (body_n) begin
            if (pkt_left == 0) begin
              queue_byte(8'($urandom), 1'b1, 1'b0);
              pkt_left = $urandom_range(0, 9);
            end else begin
              queue_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
              pkt_left--;
            end
          end
        end
      end
    end
  endtask

  // Sender: bursts of transfers with random gaps
  task automatic feed_payload();
    int burst;
    int gap;
    ts_byte_t item;
    while (payload_q.size() > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap   = $urandom_range(0, 5);
      for (int i = 0; i < burst && payload_q.size() > 0; i++) begin
        item = payload_q.pop_front();
        @(negedge clk);
        in_valid        <= 1'b1;
        in_payload_byte <= item.data;
        in_packet_first <= item.first;
        in_unit_start   <= item.start;
        do @(posedge clk); while (in_stall);
      end
      if (gap > 0 || payload_q.size() == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Wait for all results, then let the pipeline drain bytes that produce none
  task automatic settle();
    while (awaited_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_table_id(input logic [7:0] v);
    tid_cur = v;
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_table_id_match <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_payload_byte    <= 8'h00;
    in_packet_first    <= 1'b0;
    in_unit_start      <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_table_id_match <= 8'h00;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: length wrapping to zero, lengths 3, 1 and 2, a section spanning
    // packets across a non-matching start, bytes after completion, cut header
    set_table_id(8'h00);
    queue_byte(8'hff, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h03, 1'b0, 1'b0);
    queue_byte(8'hfd, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h12, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'hfe, 1'b0, 1'b0);
    queue_byte(8'h34, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h03, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'h01, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h02, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b1);
    queue_byte(8'h7e, 1'b0, 1'b0);
    queue_byte(8'ha5, 1'b1, 1'b0);
    queue_byte(8'h5a, 1'b0, 1'b1);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hc3, 1'b1, 1'b0);
    feed_payload();
    settle();

    set_table_id(8'hff);
    build_section_traffic(88, tid_cur);
    feed_payload();
    settle();

    set_table_id(8'($urandom));
    build_section_traffic(88, tid_cur);
    feed_payload();
    settle();

    // long receiver hold-off while the sender keeps offering bytes
    set_table_id(8'($urandom));
    hold_requests = hold_requests + 1;
    build_section_traffic(88, tid_cur);
    feed_payload();
    settle();

    if (mismatch_count == 0) begin
      $display("ts_psi_section_reassembler_unit_test passed");
    end else begin
      $display("ts_psi_section_reassembler_unit_test failed");
    end
    $finish;
  end

endmodule

/* ts_psi_section_reassembler_unit.f */
src/tspsi_pkg.sv
src/tspsi_core.sv
src/tspsi_outq.sv
src/ts_psi_section_reassembler_unit.sv
tb/tspsi_section_checker.sv
tb/ts_psi_section_reassembler_unit_test.sv
